### hw/rtl/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// used by tcw_cursor and text_console_writer_core, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam int CROW_W = 5;
  localparam int CCOL_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN = 8'd13;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b1;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_LAST_ROW
  } cur_op_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
  } in_t;

  typedef struct packed {
    logic [15:0]       cell_value;
    logic [CROW_W-1:0] cursor_row;
    logic [CCOL_W-1:0] cursor_col;
    logic              scrolled;
  } out_t;

endpackage

`default_nettype wire

### hw/rtl/text_console_writer_core.sv
// text_console_writer_core: top level of the text console writer
// depends on tcw_pkg and tcw_cursor
//
// A ROWS by COLS screen of 16-bit cells lives in one single-port-write,
// single-port-read memory with a registered read. After reset the block
// clears the screen to 0x0720, one cell a cycle, and holds in_stall high
// until the clear is done. A request is then accepted in S_IDLE (which
// launches the memory read of a cell read request) and, in S_EXEC, writes
// the cell or returns the read data once the output is free. A put that
// finds the cursor past the last row first scrolls: the copy loop moves
// one cell a cycle through the memory and then blanks the last row.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tcw_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tcw_pkg::out_t                         out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tcw_pkg::*;

  localparam int TOTAL  = ROWS * COLS;
  localparam int CP_END = (ROWS - 1) * COLS;
  localparam int AW = $clog2(TOTAL);
  localparam int RW = $clog2(ROWS + 1);
  localparam int CW = $clog2(COLS);
  localparam int BW = $clog2(TOTAL + 1);
  localparam int IW = AW + 8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_BLANK
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic            cp_vld_r, cp_vld_nxt;
  logic [AW-1:0]   cp_dst_r, cp_dst_nxt;
  in_t             req_r, req_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            scr_r, scr_nxt;
  logic [3:0]      bg_r, fg_r;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  logic [15:0]     mem [TOTAL];
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata;
  logic [15:0]     mem_rdata_r;

  cur_op_t         cur_op;
  logic [RW-1:0]   cur_row, cur_row_nxt;
  logic [CW-1:0]   cur_col, cur_col_nxt;
  logic [BW-1:0]   cur_base;
  logic [BW-1:0]   cell_lin;

  logic [IW-1:0]   rd_lin;
  logic            rd_in_range;
  logic            out_free;

  tcw_cursor #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (cur_op),
    .row     (cur_row),
    .col     (cur_col),
    .base    (cur_base),
    .row_nxt (cur_row_nxt),
    .col_nxt (cur_col_nxt)
  );

  assign rd_lin = IW'(in_data.read_row) * IW'(COLS) + IW'(in_data.read_col);
  assign rd_in_range = (int'(in_data.read_row) < ROWS) && (int'(in_data.read_col) < COLS);
  assign cell_lin = cur_base + BW'(cur_col);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cp_vld_nxt    = cp_vld_r;
    cp_dst_nxt    = cp_dst_r;
    req_nxt       = req_r;
    rd_ok_nxt     = rd_ok_r;
    scr_nxt       = scr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    cur_op        = CUR_HOLD;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = BLANK_CELL;
        if (ptr_r == AW'(TOTAL - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          rd_ok_nxt = rd_in_range;
          scr_nxt   = 1'b0;
          mem_re    = (in_data.req_type == REQ_READ) && rd_in_range;
          mem_raddr = rd_lin[AW-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_r.req_type == REQ_READ) begin
          if (out_free) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.cell_value = rd_ok_r ? mem_rdata_r : 16'h0000;
            out_data_nxt.cursor_row = CROW_W'(cur_row);
            out_data_nxt.cursor_col = CCOL_W'(cur_col);
            out_data_nxt.scrolled   = 1'b0;
            state_nxt               = S_IDLE;
          end
        end else if (int'(cur_row) >= ROWS) begin
          ptr_nxt    = '0;
          cp_vld_nxt = 1'b0;
          scr_nxt    = 1'b1;
          state_nxt  = S_SCROLL;
        end else if (out_free) begin
          if (req_r.char_code == CH_NEWLINE) begin
            cur_op = CUR_NEWLINE;
          end else if (req_r.char_code != CH_RETURN) begin
            cur_op    = CUR_ADVANCE;
            mem_we    = 1'b1;
            mem_waddr = cell_lin[AW-1:0];
            mem_wdata = {bg_r, fg_r, req_r.char_code};
          end
          out_valid_nxt           = 1'b1;
          out_data_nxt.cell_value = 16'h0000;
          out_data_nxt.cursor_row = CROW_W'(cur_row_nxt);
          out_data_nxt.cursor_col = CCOL_W'(cur_col_nxt);
          out_data_nxt.scrolled   = scr_r;
          state_nxt               = S_IDLE;
        end
      end
      S_SCROLL: begin
        if (cp_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = cp_dst_r;
          mem_wdata = mem_rdata_r;
        end
        if (ptr_r != AW'(CP_END)) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_r + AW'(COLS);
          cp_dst_nxt = ptr_r;
          cp_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + AW'(1);
        end else begin
          cp_vld_nxt = 1'b0;
          if (!cp_vld_r) begin
            state_nxt = S_BLANK;
          end
        end
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = BLANK_CELL;
        if (ptr_r == AW'(TOTAL - 1)) begin
          ptr_nxt   = '0;
          cur_op    = CUR_LAST_ROW;
          state_nxt = S_EXEC;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      cp_vld_r    <= 1'b0;
      scr_r       <= 1'b0;
      out_valid_r <= 1'b0;
      bg_r        <= 4'd0;
      fg_r        <= 4'd7;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cp_vld_r    <= cp_vld_nxt;
      scr_r       <= scr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BG) begin
          bg_r <= cfg_data;
        end else begin
          fg_r <= cfg_data;
        end
      end
    end
    cp_dst_r   <= cp_dst_nxt;
    req_r      <= req_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // a result only leaves the execute step
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_EXEC))
    else $error("result loaded outside execute");

  // cell writes only land on a visible row
  a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && state_r == S_EXEC |-> int'(cur_row) < ROWS)
    else $error("cell write with cursor off screen");

  // the cursor never runs more than one row past the screen
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> int'(cur_row) <= ROWS)
    else $error("cursor row out of bounds");

  // copy write never overlaps the blanking sweep
  a_copy_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BLANK |-> !cp_vld_r)
    else $error("scroll copy still pending at blank");

endmodule

`default_nettype wire

### hw/rtl/tcw_cursor.sv
// tcw_cursor: cursor row, column and row base address of the console
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF,
  localparam int RW = $clog2(ROWS + 1),
  localparam int CW = $clog2(COLS),
  localparam int BW = $clog2(ROWS * COLS + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tcw_pkg::cur_op_t op,
  output logic [RW-1:0]        row,
  output logic [CW-1:0]        col,
  output logic [BW-1:0]        base,
  output logic [RW-1:0]        row_nxt,
  output logic [CW-1:0]        col_nxt
);
  import tcw_pkg::*;

  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [BW-1:0] base_r;
  logic [BW-1:0] base_nxt;

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    unique case (op)
      CUR_HOLD: begin
      end
      CUR_NEWLINE: begin
        col_nxt  = '0;
        row_nxt  = row_r + RW'(1);
        base_nxt = base_r + BW'(COLS);
      end
      CUR_ADVANCE: begin
        if (col_r == CW'(COLS - 1)) begin
          col_nxt  = '0;
          row_nxt  = row_r + RW'(1);
          base_nxt = base_r + BW'(COLS);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      CUR_LAST_ROW: begin
        row_nxt  = RW'(ROWS - 1);
        base_nxt = BW'((ROWS - 1) * COLS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      base_r <= base_nxt;
    end
  end

  assign row  = row_r;
  assign col  = col_r;
  assign base = base_r;

endmodule

`default_nettype wire
